// ===== rtl/hvn_pkg.sv =====
// Shared constants and types for the hashed value noise core.
// No dependencies; used by the core, hvn_split and hvn_hash under rtl/.
package hvn_pkg;

	localparam logic [31:0] HASH_M1  = 32'h7feb352d;
	localparam logic [31:0] HASH_M2  = 32'h846ca68b;
	localparam logic [31:0] KEY_X    = 32'h9e3779b9;
	localparam logic [31:0] KEY_Y    = 32'h85ebca6b;
	localparam logic [17:0] SMOOTH_K = 18'd196608;
	localparam logic [16:0] ONE_Q16  = 17'd65536;

	localparam int DIV_STEPS = 4;   // restoring steps per pipeline stage
	localparam int A_STAGES  = 8;   // 32 quotient bits
	localparam int B_STAGES  = 4;   // 16 fraction bits
	localparam int SPLIT_LAT = A_STAGES + 1 + B_STAGES;
	localparam int HASH_LAT  = 2;
	localparam int TOTAL_LAT = SPLIT_LAT + 1 + HASH_LAT + 1 + HASH_LAT + 2;

	typedef struct packed {
		logic [16:0] rem;
		logic [31:0] dq;   // dividend bits shift out, quotient bits shift in
	} quo_t;

	typedef struct packed {
		logic [16:0] rem;
		logic [15:0] fq;
	} frac_t;

endpackage

// ===== rtl/hashed_value_noise_2d_core.sv =====
// Top level of the hashed 2-D value noise core.
// Uses hvn_pkg, hvn_split, hvn_hash and hvn_delay.
//
// Usage:
//   Drive seed_word, coord_x, coord_y and lattice_scale and pulse start; a
//   word is taken at every rising edge with start high and busy low. busy
//   is always low: the pipeline takes a new word every cycle.
//   Each result appears on noise_value for one cycle with valid high, in
//   input order, once the word has passed all TOTAL_LAT = 21 register stages.
//   The rate is one word per cycle; latency is set by the two division
//   pipelines (32 quotient steps plus 16 fraction steps, four per stage),
//   two chained hash stages of two multipliers each, and three blends.
//   A lattice_scale of zero acts as a scale of one.
//   Reset clears the valid pipeline so no result is shown for words in
//   flight. The receiver cannot stall; every result must be taken when shown.
module hashed_value_noise_2d_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] seed_word,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic [16:0] lattice_scale,
	output logic        valid,
	output logic [15:0] noise_value
);

	localparam int LAT = hvn_pkg::TOTAL_LAT;
	localparam int SL  = hvn_pkg::SPLIT_LAT;

	logic [LAT:1] vld_q;
	logic [31:0] gx, gy, seed_d;
	logic [15:0] fx, fy;

	logic [31:0] hx0_s14, hx1_s14, hy0_s14, hy1_s14;
	logic [31:0] hx0, hx1, hy0, hy1;
	logic [31:0] cin_s17 [4];
	logic [31:0] cout [4];
	logic [31:0] ttx_s14, tty_s14;
	logic [15:0] fx_s14, fy_s14;
	logic [15:0] ex_s15, ey_s15, tx_d, ty_d;
	logic [15:0] top_s20, bot_s20, ty_s20;

	function automatic logic [15:0] blend(logic [15:0] a, logic [15:0] b, logic [15:0] t);
		logic [33:0] sum;
		sum = 34'(a) * 34'(hvn_pkg::ONE_Q16 - {1'b0, t}) + 34'(b) * 34'(t);
		return sum[31:16];
	endfunction

	function automatic logic [15:0] ease(logic [31:0] tt, logic [15:0] t);
		logic [17:0] k;
		logic [49:0] p;
		k = hvn_pkg::SMOOTH_K - {1'b0, t, 1'b0};
		p = 50'(tt) * 50'(k);
		return p[47:32];
	endfunction

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-1:1], start};
		end
	end

	assign valid = vld_q[LAT];

	hvn_split u_split_x (.clk(clk), .coord(coord_x), .scale(lattice_scale),
		.lat_idx(gx), .frac(fx));
	hvn_split u_split_y (.clk(clk), .coord(coord_y), .scale(lattice_scale),
		.lat_idx(gy), .frac(fy));

	hvn_delay #(.W(32), .D(SL + 3)) u_seed_dly (.clk(clk), .d(seed_word), .q(seed_d));

	always_ff @(posedge clk) begin
		hx0_s14 <= gx + hvn_pkg::KEY_X;
		hx1_s14 <= gx + hvn_pkg::KEY_X + 32'd1;
		hy0_s14 <= gy + hvn_pkg::KEY_Y;
		hy1_s14 <= gy + hvn_pkg::KEY_Y + 32'd1;
		ttx_s14 <= 32'(fx) * 32'(fx);
		tty_s14 <= 32'(fy) * 32'(fy);
	end

	// the fraction is needed again for ease; held a stage to line up with tt
	always_ff @(posedge clk) begin
		fx_s14 <= fx;
		fy_s14 <= fy;
		ex_s15 <= ease(ttx_s14, fx_s14);
		ey_s15 <= ease(tty_s14, fy_s14);
	end

	hvn_delay #(.W(16), .D(4)) u_tx_dly (.clk(clk), .d(ex_s15), .q(tx_d));
	hvn_delay #(.W(16), .D(4)) u_ty_dly (.clk(clk), .d(ey_s15), .q(ty_d));

	hvn_hash u_hx0 (.clk(clk), .v(hx0_s14), .h(hx0));
	hvn_hash u_hx1 (.clk(clk), .v(hx1_s14), .h(hx1));
	hvn_hash u_hy0 (.clk(clk), .v(hy0_s14), .h(hy0));
	hvn_hash u_hy1 (.clk(clk), .v(hy1_s14), .h(hy1));

	// corner order: 00, 10, 01, 11
	always_ff @(posedge clk) begin
		cin_s17[0] <= seed_d ^ hx0 ^ hy0;
		cin_s17[1] <= seed_d ^ hx1 ^ hy0;
		cin_s17[2] <= seed_d ^ hx0 ^ hy1;
		cin_s17[3] <= seed_d ^ hx1 ^ hy1;
	end

	for (genvar c = 0; c < 4; c++) begin : g_corner
		hvn_hash u_hc (.clk(clk), .v(cin_s17[c]), .h(cout[c]));
	end

	always_ff @(posedge clk) begin
		top_s20     <= blend(cout[0][15:0], cout[1][15:0], tx_d);
		bot_s20     <= blend(cout[2][15:0], cout[3][15:0], tx_d);
		ty_s20      <= ty_d;
		noise_value <= blend(top_s20, bot_s20, ty_s20);
	end

endmodule

// ===== rtl/hvn_delay.sv =====
// Plain shift-register delay line for payload alongside the pipeline.
// No dependencies.
module hvn_delay #(
	parameter int W = 32,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] line_q [D];

	always_ff @(posedge clk) begin
		line_q[0] <= d;
		for (int i = 1; i < D; i++) begin
			line_q[i] <= line_q[i-1];
		end
	end

	assign q = line_q[D-1];

endmodule

// ===== rtl/hvn_hash.sv =====
// Two-stage multiply-xorshift hash (one multiplier per stage).
// Depends on hvn_pkg for the multiplier constants.
module hvn_hash (
	input  logic        clk,
	input  logic [31:0] v,
	output logic [31:0] h
);

	logic [31:0] m1_s1;
	logic [31:0] m2_s2;

	always_ff @(posedge clk) begin
		m1_s1 <= 32'((v ^ (v >> 16)) * hvn_pkg::HASH_M1);
		m2_s2 <= 32'((m1_s1 ^ (m1_s1 >> 15)) * hvn_pkg::HASH_M2);
	end

	assign h = m2_s2 ^ (m2_s2 >> 16);

endmodule

// ===== rtl/hvn_split.sv =====
// Pipelined floor division of a signed coordinate by the lattice scale,
// giving lattice cell and 16-bit fraction. Depends on hvn_pkg.
module hvn_split (
	input  logic        clk,
	input  logic [31:0] coord,
	input  logic [16:0] scale,
	output logic [31:0] lat_idx,
	output logic [15:0] frac
);

	localparam int NA = hvn_pkg::A_STAGES;
	localparam int NB = hvn_pkg::B_STAGES;

	function automatic hvn_pkg::quo_t quo_steps(hvn_pkg::quo_t in, logic [16:0] s);
		logic [17:0] t;
		hvn_pkg::quo_t v;
		v = in;
		for (int i = 0; i < hvn_pkg::DIV_STEPS; i++) begin
			t = {v.rem, v.dq[31]};
			v.dq = {v.dq[30:0], 1'b0};
			if (t >= {1'b0, s}) begin
				v.rem = 17'(t - {1'b0, s});
				v.dq[0] = 1'b1;
			end else begin
				v.rem = t[16:0];
			end
		end
		return v;
	endfunction

	function automatic hvn_pkg::frac_t frac_steps(hvn_pkg::frac_t in, logic [16:0] s);
		logic [17:0] t;
		hvn_pkg::frac_t v;
		v = in;
		for (int i = 0; i < hvn_pkg::DIV_STEPS; i++) begin
			t = {v.rem, 1'b0};
			v.fq = {v.fq[14:0], 1'b0};
			if (t >= {1'b0, s}) begin
				v.rem = 17'(t - {1'b0, s});
				v.fq[0] = 1'b1;
			end else begin
				v.rem = t[16:0];
			end
		end
		return v;
	endfunction

	hvn_pkg::quo_t  qa_s [NA];
	logic [16:0]    sa_s [NA];
	logic           na_s [NA];
	hvn_pkg::frac_t fb_s [NB+1];
	logic [16:0]    sb_s [NB+1];
	logic [31:0]    cb_s [NB+1];

	logic [16:0]   s_in;
	hvn_pkg::quo_t q_in;

	// negative coordinates divide ~x and flip back: floor = ~q, rem = s-1-r
	assign s_in = (scale == '0) ? 17'd1 : scale;
	assign q_in = '{rem: '0, dq: {1'b0, (coord[31] ? ~coord[30:0] : coord[30:0])}};

	always_ff @(posedge clk) begin
		qa_s[0] <= quo_steps(q_in, s_in);
		sa_s[0] <= s_in;
		na_s[0] <= coord[31];
		for (int g = 1; g < NA; g++) begin
			qa_s[g] <= quo_steps(qa_s[g-1], sa_s[g-1]);
			sa_s[g] <= sa_s[g-1];
			na_s[g] <= na_s[g-1];
		end
		fb_s[0].rem <= na_s[NA-1] ? 17'(sa_s[NA-1] - 17'd1 - qa_s[NA-1].rem)
		                          : qa_s[NA-1].rem;
		fb_s[0].fq  <= '0;
		sb_s[0]     <= sa_s[NA-1];
		cb_s[0]     <= na_s[NA-1] ? ~qa_s[NA-1].dq : qa_s[NA-1].dq;
		for (int g = 1; g <= NB; g++) begin
			fb_s[g] <= frac_steps(fb_s[g-1], sb_s[g-1]);
			sb_s[g] <= sb_s[g-1];
			cb_s[g] <= cb_s[g-1];
		end
	end

	assign lat_idx = cb_s[NB];
	assign frac    = fb_s[NB].fq;

endmodule
